[sv/hcbp_pkg.sv]
`timescale 1ns / 1ps

package hcbp_pkg;

	localparam int SYM_W            = 8;
	localparam int NUM_SYMBOLS      = 256;
	localparam int CODE_W           = 32;
	localparam int LEN_W            = 6;
	localparam int BYTE_W           = 8;
	localparam int PEND_W           = 7;
	localparam int ACC_W            = PEND_W + CODE_W;
	localparam int TOT_W            = 6;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_ENCODE = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	// one table entry, code right-aligned
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} code_t;

	// work handed from the front to the back
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} entry_t;

endpackage

[sv/hcbp_front.sv]
`timescale 1ns / 1ps

module hcbp_front #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [hcbp_pkg::SYM_W-1:0]     symbol,
	input  logic [hcbp_pkg::CODE_W-1:0]    code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]     code_len,
	output logic                           push_valid,
	input  logic                           push_ready,
	output hcbp_pkg::entry_t               push_entry
);

	localparam int LenLimInt = (MAX_CODE_LEN > hcbp_pkg::CODE_W) ?
		hcbp_pkg::CODE_W : MAX_CODE_LEN;
	localparam logic [hcbp_pkg::LEN_W-1:0] LEN_LIM = hcbp_pkg::LEN_W'(LenLimInt);

	hcbp_pkg::code_t                  table_mem [hcbp_pkg::NUM_SYMBOLS];
	logic [hcbp_pkg::NUM_SYMBOLS-1:0] vld_q;

	logic                             valid_s1;
	logic                             flush_s1;
	logic                             rd_vld_s1;
	hcbp_pkg::code_t                  rd_code_s1;

	logic                             accept;
	logic                             is_load;
	logic                             is_work;
	logic [hcbp_pkg::LEN_W-1:0]       clen_c;
	logic [hcbp_pkg::CODE_W-1:0]      mask_c;
	logic [hcbp_pkg::LEN_W-1:0]       len_s1;
	logic                             drop_s1;
	logic                             done_s1;

	assign accept  = in_valid && in_ready;
	assign is_load = (req_type == hcbp_pkg::REQ_LOAD);
	assign is_work = (req_type == hcbp_pkg::REQ_ENCODE) || (req_type == hcbp_pkg::REQ_FLUSH);
	assign clen_c  = (code_len > LEN_LIM) ? LEN_LIM : code_len;
	// shift by the full width gives all ones
	assign mask_c  = ~({hcbp_pkg::CODE_W{1'b1}} << clen_c);

	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			table_mem[symbol] <= '{len: clen_c, bits: code_bits & mask_c};
		end
		if (accept) begin
			rd_code_s1 <= table_mem[symbol];
			rd_vld_s1  <= vld_q[symbol];
			flush_s1   <= (req_type == hcbp_pkg::REQ_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (accept && is_load) begin
			vld_q[symbol] <= 1'b1;
		end
	end

	// never-loaded entries read as length zero
	assign len_s1   = rd_vld_s1 ? rd_code_s1.len : '0;
	assign drop_s1  = !flush_s1 && (len_s1 == '0);
	assign done_s1  = valid_s1 && (drop_s1 || push_ready);
	assign in_ready = !valid_s1 || done_s1;

	assign push_valid       = valid_s1 && !drop_s1;
	assign push_entry.flush = flush_s1;
	assign push_entry.bits  = rd_code_s1.bits;
	assign push_entry.len   = len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && is_work;
		end
	end

	a_push_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> valid_s1)
		else $error("push without a staged item");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (valid_s1 && $stable(len_s1) && $stable(flush_s1)))
		else $error("staged item changed while stalled");

endmodule

[sv/hcbp_queue.sv]
`timescale 1ns / 1ps

module hcbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  hcbp_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output hcbp_pkg::entry_t pop_entry
);

	hcbp_pkg::entry_t            slot_q [hcbp_pkg::QUEUE_DEPTH];
	logic [hcbp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hcbp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hcbp_pkg::QPTR_W:0]   count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (count_q != (hcbp_pkg::QPTR_W+1)'(hcbp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/hcbp_back.sv]
`timescale 1ns / 1ps

module hcbp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  hcbp_pkg::entry_t             pop_entry,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0]  out_byte,
	output logic                         out_last
);

	logic [hcbp_pkg::ACC_W-1:0]  acc_q;
	logic [hcbp_pkg::TOT_W-1:0]  total_q;
	logic                        out_valid_q;
	logic [hcbp_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;

	logic                        advance;
	logic                        has_byte;
	logic                        can_pop;
	logic                        do_pop;
	logic [hcbp_pkg::TOT_W-1:0]  rem;
	logic [hcbp_pkg::PEND_W-1:0] pend;
	logic [hcbp_pkg::ACC_W-1:0]  shifted;
	logic [hcbp_pkg::ACC_W-1:0]  merged;
	logic [hcbp_pkg::BYTE_W-1:0] flush_byte;
	logic [3:0]                  flush_sh;

	assign advance  = !out_valid_q || out_ready;
	assign has_byte = (total_q >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
	// bits left once this cycle's byte, if any, has gone out
	assign rem      = has_byte ? total_q - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W) : total_q;
	// an encode may load during the last byte of the one before; a flush may not
	assign can_pop  = pop_entry.flush ? !has_byte :
		(rem < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
	assign pop_ready = advance && can_pop;
	assign do_pop    = pop_valid && pop_ready;

	assign pend    = acc_q[hcbp_pkg::PEND_W-1:0] & ~({hcbp_pkg::PEND_W{1'b1}} << rem[2:0]);
	assign shifted = acc_q >> (total_q - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
	assign merged  = ({{hcbp_pkg::CODE_W{1'b0}}, pend} << pop_entry.len)
		| {{hcbp_pkg::PEND_W{1'b0}}, pop_entry.bits};
	assign flush_sh   = 4'(hcbp_pkg::BYTE_W) - {1'b0, total_q[2:0]};
	assign flush_byte = {1'b0, pend} << flush_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b0;
			if (has_byte) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= shifted[hcbp_pkg::BYTE_W-1:0];
				out_last_q  <= (rem < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
				total_q     <= rem;
			end
			if (do_pop) begin
				if (pop_entry.flush) begin
					if (total_q != '0) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= flush_byte;
						out_last_q  <= 1'b1;
					end
					acc_q   <= '0;
					total_q <= '0;
				end else begin
					acc_q   <= merged;
					total_q <= rem + pop_entry.len;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= hcbp_pkg::TOT_W'(hcbp_pkg::ACC_W))
		else $error("accumulator count out of range");

	a_flush_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && pop_entry.flush) |-> (total_q < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W)))
		else $error("flush taken with whole bytes pending");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(total_q) && $stable(acc_q)))
		else $error("accumulator moved while output stalled");

endmodule

[sv/huffman_code_bit_packer.sv]
`timescale 1ns / 1ps

// Prefix-code bit packer. A load item (tuser 0) writes one of 256 code table entries, an
// encode item (tuser 1) appends the code of a byte MSB first, a flush item (tuser 2) pads
// any partial byte with zeros. Bytes leave on the master side with tlast on the final byte
// of each item; loads and items that complete no byte produce nothing. The front takes one
// item per cycle while the queue has room (table read registered) into a 4-entry queue;
// the back has one output byte register; an encode may load during the last byte of
// the one before, a flush may not. The table is empty after reset with no clearing pass.
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // symbol[7:0], code_bits[39:8], code_len[45:40], zero pad
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // packed_byte[7:0]
	output logic        m_tlast
);

	logic             push_valid;
	logic             push_ready;
	hcbp_pkg::entry_t push_entry;
	logic             pop_valid;
	logic             pop_ready;
	hcbp_pkg::entry_t pop_entry;

	hcbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.symbol    (s_tdata[7:0]),
		.code_bits (s_tdata[39:8]),
		.code_len  (s_tdata[45:40]),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	hcbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	hcbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

endmodule
